/* hdl/adsbv_pkg.sv */
// Package with the shared types, constants and angle table of the airborne velocity decoder.
`default_nettype none

package adsbv_pkg;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_SUBTYPE = 2'd1,
    ST_NOT_AVAIL   = 2'd2
  } status_t;

  localparam logic [2:0] SUB_GND_NORMAL = 3'd1;
  localparam logic [2:0] SUB_GND_SUPER  = 3'd2;
  localparam logic [2:0] SUB_AIR_NORMAL = 3'd3;
  localparam logic [2:0] SUB_AIR_SUPER  = 3'd4;

  localparam logic [30:0] ANG_90     = 31'd1509949440;
  localparam logic [29:0] GAIN_Q30   = 30'd652032874;
  localparam logic [15:0] FULL_TURN  = 16'd46080;
  localparam logic [15:0] HALF_TURN  = 16'd23040;
  localparam logic [5:0]  HDG_SCALE  = 6'd45;
  localparam int          MAX_STEPS  = 32;

  localparam logic [31:0] ATAN_TAB [MAX_STEPS] = '{
    32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
    32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
    32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
    32'd234684,    32'd117342,    32'd58671,     32'd29335,
    32'd14668,     32'd7334,      32'd3667,      32'd1833,
    32'd917,       32'd458,       32'd229,       32'd115,
    32'd57,        32'd29,        32'd14,        32'd7,
    32'd4,         32'd2,         32'd1,         32'd0
  };

  typedef struct packed {
    status_t            status;
    logic               src;
    logic [16:0]        spd;
    logic               hvalid;
    logic [15:0]        hdg;
    logic signed [15:0] vr;
    logic               cordic_en;
    logic               ew_neg;
    logic               ns_neg;
  } meta_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    meta_t              meta;
  } cordic_word_t;

endpackage

`default_nettype wire

/* hdl/adsbv_if.sv */
// Handshake interfaces for the message and result channels of the velocity decoder.
`default_nettype none

interface adsbv_msg_if;
  logic        valid;
  logic        ready;
  logic [55:0] me_field;

  modport source (output valid, output me_field, input ready);
  modport sink (input valid, input me_field, output ready);
endinterface

interface adsbv_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               speed_source;
  logic [16:0]        speed_sixteenths;
  logic               heading_valid;
  logic [15:0]        heading_units;
  logic signed [15:0] vertical_rate;

  modport source (output valid, output status, output speed_source,
                  output speed_sixteenths, output heading_valid,
                  output heading_units, output vertical_rate, input ready);
  modport sink (input valid, input status, input speed_source,
                input speed_sixteenths, input heading_valid,
                input heading_units, input vertical_rate, output ready);
endinterface

`default_nettype wire

/* hdl/adsb_airborne_velocity_decode.sv */
// Top level of the ADS-B airborne velocity decoder: field decode, CORDIC cell row and output stage.
//
// Each word on msg is one 56-bit airborne velocity ME field; each word on res is its decoded
// status, speed, heading and vertical rate. The block keeps no state between messages and
// accepts one word per cycle unless the row is full and stalled by res. A word reaches the
// output register through CORDIC_STEPS + 1 register stages: the field decode and the first
// rotation share the first cell, every further cell performs one rotation, and the output stage
// scales the magnitude and folds the heading.
// Each cell and the output register stall only when they hold a word that the next stage does
// not take, so gaps in the row are filled while a result waits on res.
`default_nettype none

module adsb_airborne_velocity_decode
  import adsbv_pkg::*;
#(
  parameter int CORDIC_STEPS = 20
) (
  input  wire logic  clk,
  input  wire logic  rst,
  adsbv_msg_if.sink  msg,
  adsbv_res_if.source res
);

  cordic_word_t front_word;
  cordic_word_t words [CORDIC_STEPS + 1];
  logic         valids [CORDIC_STEPS + 1];
  logic         readys [CORDIC_STEPS + 1];

  adsbv_front u_front (
    .me_field (msg.me_field),
    .word     (front_word)
  );

  assign words[0]  = front_word;
  assign valids[0] = msg.valid;
  assign msg.ready = readys[0];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    adsbv_cell #(
      .STEP (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (valids[i]),
      .up_ready (readys[i]),
      .up_word  (words[i]),
      .dn_valid (valids[i + 1]),
      .dn_ready (readys[i + 1]),
      .dn_word  (words[i + 1])
    );
  end

  adsbv_finish u_finish (
    .clk      (clk),
    .rst      (rst),
    .up_valid (valids[CORDIC_STEPS]),
    .up_ready (readys[CORDIC_STEPS]),
    .up_word  (words[CORDIC_STEPS]),
    .res      (res)
  );

endmodule

`default_nettype wire

/* hdl/adsbv_front.sv */
// Field decoder that splits an ME word into result fields and the starting CORDIC vector.
`default_nettype none

module adsbv_front
  import adsbv_pkg::*;
(
  input  wire logic [55:0] me_field,
  output cordic_word_t     word
);

  logic [2:0]         st;
  logic [8:0]         vr_raw;
  logic [14:0]        vr_mag;
  logic signed [15:0] vr;
  logic [9:0]         ew_raw;
  logic [9:0]         ns_raw;
  logic [11:0]        ew;
  logic [11:0]        ns;
  logic [11:0]        as_val;
  logic [15:0]        hdg_air;

  always_comb begin
    st     = me_field[50:48];
    vr_raw = {me_field[17:16], me_field[15:9]};
    vr_mag = 15'({6'd0, vr_raw - 9'd1} << 6);
    if (vr_raw == 9'd0) begin
      vr = 16'sd0;
    end else if (me_field[18]) begin
      vr = -$signed({1'b0, vr_mag});
    end else begin
      vr = $signed({1'b0, vr_mag});
    end
    ew_raw  = {me_field[41:40], me_field[39:32]};
    ns_raw  = {me_field[30:24], me_field[23:21]};
    ew      = (st == SUB_GND_SUPER) ? {ew_raw - 10'd1, 2'b00} : {2'b00, ew_raw - 10'd1};
    ns      = (st == SUB_GND_SUPER) ? {ns_raw - 10'd1, 2'b00} : {2'b00, ns_raw - 10'd1};
    as_val  = (st == SUB_AIR_SUPER) ? {ns_raw - 10'd1, 2'b00} : {2'b00, ns_raw - 10'd1};
    hdg_air = {6'd0, ew_raw} * {10'd0, HDG_SCALE};

    word.x = $signed({4'd0, ns, 16'd0});
    word.y = $signed({4'd0, ew, 16'd0});
    word.z = 32'sd0;
    word.meta = '0;
    word.meta.status = ST_OK;
    word.meta.vr = vr;
    unique case (st) inside
      SUB_GND_NORMAL, SUB_GND_SUPER: begin
        if (ew_raw == 10'd0 || ns_raw == 10'd0) begin
          word.meta.status = ST_NOT_AVAIL;
        end else begin
          word.meta.hvalid    = 1'b1;
          word.meta.cordic_en = (ew != 12'd0) || (ns != 12'd0);
          word.meta.ew_neg    = me_field[42] && (ew != 12'd0);
          word.meta.ns_neg    = me_field[31] && (ns != 12'd0);
        end
      end
      SUB_AIR_NORMAL, SUB_AIR_SUPER: begin
        if (ns_raw == 10'd0) begin
          word.meta.status = ST_NOT_AVAIL;
        end else begin
          word.meta.src    = 1'b1;
          word.meta.spd    = {1'b0, as_val, 4'd0};
          word.meta.hvalid = me_field[42];
          word.meta.hdg    = me_field[42] ? hdg_air : 16'd0;
        end
      end
      default: begin
        word.meta.status = ST_BAD_SUBTYPE;
      end
    endcase
    if (word.meta.status != ST_OK) begin
      word.meta.vr = 16'sd0;
    end
  end

endmodule

`default_nettype wire

/* hdl/adsbv_cell.sv */
// One CORDIC vectoring cell that rotates its word by a fixed step and hands it on.
`default_nettype none

module adsbv_cell
  import adsbv_pkg::*;
#(
  parameter int STEP = 0
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          up_valid,
  output logic               up_ready,
  input  wire cordic_word_t  up_word,
  output logic               dn_valid,
  input  wire logic          dn_ready,
  output cordic_word_t       dn_word
);

  localparam logic [31:0] ATAN_STEP = ATAN_TAB[STEP];

  cordic_word_t       word_next;
  logic signed [31:0] dx;
  logic signed [31:0] dy;

  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    dx = up_word.y >>> STEP;
    dy = up_word.x >>> STEP;
    word_next = up_word;
    if (up_word.y >= 0) begin
      word_next.x = up_word.x + dx;
      word_next.y = up_word.y - dy;
      word_next.z = up_word.z + $signed(ATAN_STEP);
    end else begin
      word_next.x = up_word.x - dx;
      word_next.y = up_word.y + dy;
      word_next.z = up_word.z - $signed(ATAN_STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_word <= word_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/adsbv_finish.sv */
// Output stage that scales the CORDIC magnitude, folds the heading and holds the result.
`default_nettype none

module adsbv_finish
  import adsbv_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         up_valid,
  output logic              up_ready,
  input  wire cordic_word_t up_word,
  adsbv_res_if.source       res
);

  logic [30:0] xc;
  logic [30:0] zc;
  logic [31:0] zr;
  logic [13:0] ang;
  logic [61:0] prod;
  logic [61:0] prod_rnd;
  logic [15:0] hdg_raw;
  logic [15:0] hdg;
  logic [16:0] spd;

  assign up_ready = !res.valid || res.ready;

  always_comb begin
    xc = (up_word.x < 0) ? 31'd0 : up_word.x[30:0];
    if (up_word.z < 0) begin
      zc = 31'd0;
    end else if (up_word.z > $signed({1'b0, ANG_90})) begin
      zc = ANG_90;
    end else begin
      zc = up_word.z[30:0];
    end
    zr       = {1'b0, zc} + 32'd65536;
    ang      = zr[30:17];
    prod     = 62'(xc) * 62'(GAIN_Q30);
    prod_rnd = prod + (62'd1 << 41);
    case ({up_word.meta.ew_neg, up_word.meta.ns_neg})
      2'b11:   hdg_raw = HALF_TURN + {2'd0, ang};
      2'b10:   hdg_raw = FULL_TURN - {2'd0, ang};
      2'b01:   hdg_raw = HALF_TURN - {2'd0, ang};
      default: hdg_raw = {2'd0, ang};
    endcase
    hdg = (hdg_raw >= FULL_TURN) ? hdg_raw - FULL_TURN : hdg_raw;
    spd = prod_rnd[58:42];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (up_ready) begin
      res.valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      res.status           <= up_word.meta.status;
      res.speed_source     <= up_word.meta.src;
      res.heading_valid    <= up_word.meta.hvalid;
      res.vertical_rate    <= up_word.meta.vr;
      res.speed_sixteenths <= up_word.meta.cordic_en ? spd : up_word.meta.spd;
      res.heading_units    <= up_word.meta.cordic_en ? hdg : up_word.meta.hdg;
    end
  end

endmodule

`default_nettype wire

/* hdl/adsbv_check.sv */
// Port checker for the airborne velocity decoder and its binding to the top level.
`default_nettype none

module adsbv_check
  import adsbv_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [1:0]  res_status,
  input wire logic        res_speed_source,
  input wire logic [16:0] res_speed_sixteenths,
  input wire logic        res_heading_valid,
  input wire logic [15:0] res_heading_units,
  input wire logic [15:0] res_vertical_rate
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("Result word valid right after reset.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("Result word dropped while stalled.");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status != ST_OK |->
      !res_speed_source && res_speed_sixteenths == 17'd0 && !res_heading_valid &&
      res_heading_units == 16'd0 && res_vertical_rate == 16'd0)
    else $error("Failed message carries nonzero fields.");

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_heading_units < FULL_TURN &&
      (res_heading_valid || res_heading_units == 16'd0))
    else $error("Heading out of range or set while not valid.");

  a_airspeed_grid: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_speed_source |-> res_speed_sixteenths[3:0] == 4'd0)
    else $error("Airspeed is not a whole number of knots.");

endmodule

bind adsb_airborne_velocity_decode adsbv_check u_adsbv_check (
  .clk                  (clk),
  .rst                  (rst),
  .res_valid            (res.valid),
  .res_ready            (res.ready),
  .res_status           (res.status),
  .res_speed_source     (res.speed_source),
  .res_speed_sixteenths (res.speed_sixteenths),
  .res_heading_valid    (res.heading_valid),
  .res_heading_units    (res.heading_units),
  .res_vertical_rate    (res.vertical_rate)
);

`default_nettype wire

/* tb/sv/adsb_airborne_velocity_decode_tb.sv */
// Self-checking testbench for the airborne velocity decoder with a bit-exact CORDIC predictor.
`timescale 1ns / 1ps

module adsb_airborne_velocity_decode_tb;
  import adsbv_pkg::*;

  localparam int          CORDIC_STEPS    = 20;
  localparam int          CYCLE_LIMIT     = 1000000;
  localparam int          MAX_PRINTED     = 40;
  localparam int unsigned TURN_UNITS      = 46080;
  localparam int unsigned HALF_TURN_UNITS = 23040;
  localparam longint      RIGHT_ANGLE     = 64'sd1509949440;
  localparam longint unsigned INV_GAIN_Q30 = 64'd652032874;

  localparam longint ATAN_STEP [32] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct packed {
    status_t            status;
    logic               src;
    logic [16:0]        spd;
    logic               hvalid;
    logic [15:0]        hdg;
    logic signed [15:0] vr;
  } velocity_report_t;

  typedef struct {
    logic [55:0]      me;
    velocity_report_t report;
  } pending_report_t;

  logic clk;
  logic rst;

  adsbv_msg_if msg_bus ();
  adsbv_res_if res_bus ();

  adsb_airborne_velocity_decode #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .msg(msg_bus),
    .res(res_bus)
  );

  pending_report_t expected_reports [$];
  int error_count;
  int words_sent;
  int results_checked;
  int ok_count;
  int bad_subtype_count;
  int not_avail_count;
  int cycle_count;
  int burst_left;
  bit gapless;
  int stall_left;
  int stall_mode;
  int stall_phase;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic void cordic_vector(input int unsigned east, input int unsigned north,
                                        output int unsigned speed, output int unsigned angle);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint unsigned prod;
    x = longint'(north) <<< 16;
    y = longint'(east) <<< 16;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_STEP[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_STEP[i];
      end
    end
    if (z < 0) z = 0;
    if (z > RIGHT_ANGLE) z = RIGHT_ANGLE;
    if (x < 0) x = 0;
    angle = int'((z + 65536) >>> 17);
    prod = longint'(x) * INV_GAIN_Q30 + (64'd1 << 41);
    speed = int'(prod >> 42);
  endfunction

  function automatic velocity_report_t decode_velocity(input logic [55:0] me);
    velocity_report_t r;
    status_t          st;
    logic [2:0]       sub;
    logic [8:0]       vr_raw;
    int unsigned      ew;
    int unsigned      ns;
    int unsigned      airspeed;
    int unsigned      spd;
    int unsigned      ang;
    int unsigned      hdg;
    int               mag;
    bit               east_neg;
    bit               north_neg;
    r = '0;
    sub = me[50:48];
    vr_raw = me[17:9];
    if (vr_raw != 0) begin
      mag = (int'(vr_raw) - 1) * 64;
      r.vr = 16'(me[18] ? -mag : mag);
    end
    if (sub < SUB_GND_NORMAL || sub > SUB_AIR_SUPER) begin
      r.status = ST_BAD_SUBTYPE;
    end else if (sub <= SUB_GND_SUPER) begin
      ew = me[41:32];
      ns = me[30:21];
      if (ew == 0 || ns == 0) begin
        r.status = ST_NOT_AVAIL;
      end else begin
        ew = ew - 1;
        ns = ns - 1;
        if (sub == SUB_GND_SUPER) begin
          ew = ew * 4;
          ns = ns * 4;
        end
        r.hvalid = 1'b1;
        if (ew != 0 || ns != 0) begin
          cordic_vector(ew, ns, spd, ang);
          r.spd = spd[16:0];
          east_neg = me[42] && ew != 0;
          north_neg = me[31] && ns != 0;
          if (east_neg) hdg = north_neg ? HALF_TURN_UNITS + ang : TURN_UNITS - ang;
          else hdg = north_neg ? HALF_TURN_UNITS - ang : ang;
          if (hdg >= TURN_UNITS) hdg = hdg - TURN_UNITS;
          r.hdg = hdg[15:0];
        end
      end
    end else begin
      airspeed = me[30:21];
      if (airspeed == 0) begin
        r.status = ST_NOT_AVAIL;
      end else begin
        r.src = 1'b1;
        airspeed = airspeed - 1;
        if (sub == SUB_AIR_SUPER) airspeed = airspeed * 4;
        r.spd = 17'(airspeed * 16);
        if (me[42]) begin
          r.hvalid = 1'b1;
          hdg = int'(me[41:32]) * 45;
          r.hdg = hdg[15:0];
        end
      end
    end
    if (r.status != ST_OK) begin
      st = r.status;
      r = '0;
      r.status = st;
    end
    return r;
  endfunction

  function automatic logic [55:0] build_field(input logic [2:0] sub, input logic flag42,
                                              input logic [9:0] ew, input logic ns_neg,
                                              input logic [9:0] ns, input logic vr_neg,
                                              input logic [8:0] vr_raw);
    logic [55:0] f;
    f = 56'({$urandom, $urandom});
    f[50:48] = sub;
    f[42] = flag42;
    f[41:32] = ew;
    f[31] = ns_neg;
    f[30:21] = ns;
    f[18] = vr_neg;
    f[17:9] = vr_raw;
    return f;
  endfunction

  function automatic logic [9:0] pick_magnitude();
    case ($urandom_range(0, 3))
      0: return 10'($urandom_range(1, 9));
      1: return 10'($urandom_range(1000, 1023));
      default: return 10'($urandom_range(1, 1023));
    endcase
  endfunction

  function automatic logic [55:0] random_word();
    int          pick;
    int          s;
    logic [55:0] f;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      f = build_field(3'($urandom_range(1, 4)), 1'($urandom), pick_magnitude(),
                      1'($urandom), pick_magnitude(), 1'($urandom),
                      9'($urandom_range(0, 511)));
    end else if (pick < 85) begin
      f = build_field(3'($urandom_range(1, 4)), 1'($urandom), pick_magnitude(),
                      1'($urandom), pick_magnitude(), 1'($urandom),
                      9'($urandom_range(0, 511)));
      case ($urandom_range(0, 3))
        0: begin
          s = $urandom_range(0, 3);
          f[50:48] = (s == 0) ? 3'd0 : 3'(s + 4);
        end
        1: begin
          f[50:48] = 3'($urandom_range(1, 2));
          f[41:32] = '0;
        end
        2: begin
          f[50:48] = 3'($urandom_range(1, 2));
          f[30:21] = '0;
        end
        default: begin
          f[50:48] = 3'($urandom_range(3, 4));
          f[30:21] = '0;
        end
      endcase
    end else begin
      f = 56'({$urandom, $urandom});
    end
    return f;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want,
                                 input logic [55:0] me);
    if (error_count < MAX_PRINTED)
      $display("[%0t] mismatch %s on result %0d (me %014h): got %0d, expected %0d",
               $time, what, results_checked, me, got, want);
    error_count++;
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      @(negedge clk);
      msg_bus.valid <= 1'b0;
      msg_bus.me_field <= 56'({$urandom, $urandom});
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic send_item(input logic [55:0] f);
    if (!gapless) begin
      if (burst_left == 0) begin
        if ($urandom_range(0, 9) == 0) idle_cycles($urandom_range(5, 30));
        else idle_cycles($urandom_range(0, 4));
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    @(negedge clk);
    msg_bus.valid <= 1'b1;
    msg_bus.me_field <= f;
    do @(posedge clk); while (!msg_bus.ready);
    expected_reports.push_back('{f, decode_velocity(f)});
    words_sent++;
  endtask

  task automatic test_ground_directed();
    send_item(build_field(SUB_GND_NORMAL, 1'b1, 10'd1, 1'b1, 10'd1, 1'b0, 9'd0));
    send_item(build_field(SUB_GND_NORMAL, 1'b0, 10'd1023, 1'b0, 10'd1023, 1'b0, 9'd511));
    send_item(build_field(SUB_GND_SUPER, 1'b1, 10'd1023, 1'b1, 10'd1023, 1'b1, 9'd511));
    send_item(build_field(SUB_GND_NORMAL, 1'b1, 10'd11, 1'b0, 10'd1, 1'b0, 9'd2));
    send_item(build_field(SUB_GND_NORMAL, 1'b1, 10'd1, 1'b1, 10'd101, 1'b1, 9'd3));
    send_item(build_field(SUB_GND_NORMAL, 1'b0, 10'd51, 1'b0, 10'd101, 1'b0, 9'd20));
    send_item(build_field(SUB_GND_NORMAL, 1'b0, 10'd51, 1'b1, 10'd101, 1'b0, 9'd20));
    send_item(build_field(SUB_GND_NORMAL, 1'b1, 10'd51, 1'b1, 10'd101, 1'b0, 9'd20));
    send_item(build_field(SUB_GND_NORMAL, 1'b1, 10'd51, 1'b0, 10'd101, 1'b0, 9'd20));
    send_item(build_field(SUB_GND_SUPER, 1'b0, 10'd2, 1'b1, 10'd1, 1'b0, 9'd1));
  endtask

  task automatic test_air_directed();
    send_item(build_field(SUB_AIR_NORMAL, 1'b1, 10'd0, 1'b0, 10'd1, 1'b0, 9'd0));
    send_item(build_field(SUB_AIR_NORMAL, 1'b1, 10'd1023, 1'b1, 10'd1023, 1'b0, 9'd511));
    send_item(build_field(SUB_AIR_SUPER, 1'b0, 10'd1023, 1'b0, 10'd1023, 1'b1, 9'd511));
    send_item(build_field(SUB_AIR_SUPER, 1'b1, 10'd512, 1'b1, 10'd2, 1'b1, 9'd1));
    send_item(build_field(SUB_AIR_NORMAL, 1'b0, 10'd300, 1'b0, 10'd250, 1'b1, 9'd0));
  endtask

  task automatic test_error_directed();
    logic [55:0] f;
    f = '1;
    f[50:48] = 3'd0;
    send_item(f);
    f[50:48] = 3'd5;
    send_item(f);
    f[50:48] = 3'd6;
    send_item(f);
    send_item('1);
    send_item('0);
    send_item(build_field(SUB_GND_NORMAL, 1'b1, 10'd0, 1'b1, 10'd500, 1'b1, 9'd300));
    send_item(build_field(SUB_GND_SUPER, 1'b0, 10'd700, 1'b1, 10'd0, 1'b0, 9'd100));
    send_item(build_field(SUB_AIR_NORMAL, 1'b1, 10'd900, 1'b0, 10'd0, 1'b1, 9'd511));
    send_item(build_field(SUB_AIR_SUPER, 1'b1, 10'd1023, 1'b1, 10'd0, 1'b0, 9'd7));
  endtask

  task automatic test_random_traffic(input int n);
    repeat (n) send_item(random_word());
  endtask

  task automatic test_back_to_back(input int n);
    gapless = 1'b1;
    repeat (n) send_item(random_word());
    gapless = 1'b0;
  endtask

  task automatic test_drain_pauses(input int rounds, input int per_round);
    repeat (rounds) begin
      repeat (per_round) send_item(random_word());
      @(negedge clk);
      msg_bus.valid <= 1'b0;
      wait (expected_reports.size() == 0);
    end
  endtask

  initial begin
    res_bus.ready = 1'b0;
    stall_left = 0;
    stall_mode = 0;
    stall_phase = 0;
    forever begin
      @(negedge clk);
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = (stall_mode == 3) ? $urandom_range(6, 40) : $urandom_range(8, 120);
        stall_phase = 0;
      end
      case (stall_mode)
        0: res_bus.ready <= 1'b1;
        1: res_bus.ready <= ($urandom_range(0, 3) != 0);
        2: res_bus.ready <= (stall_phase % 3 == 0);
        default: res_bus.ready <= (stall_left <= 4);
      endcase
      stall_left--;
      stall_phase++;
    end
  end

  always @(posedge clk) begin : check_results
    pending_report_t want;
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (expected_reports.size() == 0) begin
        report_mismatch("unexpected word", 0, 0, '0);
      end else begin
        want = expected_reports.pop_front();
        if (res_bus.status !== want.report.status)
          report_mismatch("status", res_bus.status, want.report.status, want.me);
        if (res_bus.speed_source !== want.report.src)
          report_mismatch("speed_source", res_bus.speed_source, want.report.src, want.me);
        if (res_bus.speed_sixteenths !== want.report.spd)
          report_mismatch("speed_sixteenths", res_bus.speed_sixteenths, want.report.spd,
                          want.me);
        if (res_bus.heading_valid !== want.report.hvalid)
          report_mismatch("heading_valid", res_bus.heading_valid, want.report.hvalid, want.me);
        if (res_bus.heading_units !== want.report.hdg)
          report_mismatch("heading_units", res_bus.heading_units, want.report.hdg, want.me);
        if (res_bus.vertical_rate !== want.report.vr)
          report_mismatch("vertical_rate", res_bus.vertical_rate, want.report.vr, want.me);
        case (want.report.status)
          ST_OK: ok_count++;
          ST_BAD_SUBTYPE: bad_subtype_count++;
          default: not_avail_count++;
        endcase
      end
      results_checked++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words outstanding", cycle_count,
               expected_reports.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    error_count = 0;
    words_sent = 0;
    results_checked = 0;
    ok_count = 0;
    bad_subtype_count = 0;
    not_avail_count = 0;
    cycle_count = 0;
    burst_left = 0;
    gapless = 1'b0;
    rst = 1'b1;
    msg_bus.valid = 1'b0;
    msg_bus.me_field = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_ground_directed();
    test_air_directed();
    test_error_directed();
    test_random_traffic(1200);
    test_back_to_back(300);
    test_drain_pauses(5, 50);

    @(negedge clk);
    msg_bus.valid <= 1'b0;
    wait (expected_reports.size() == 0);
    repeat (CORDIC_STEPS + 20) @(posedge clk);

    $display("Sent %0d message words and checked %0d results over %0d cycles.",
             words_sent, results_checked, cycle_count);
    $display("Results by status: %0d ok, %0d bad subtype, %0d not available.",
             ok_count, bad_subtype_count, not_avail_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
